### hw/rtl/fitch_parsimony_site_combiner_assert.svh
// Assertion macros used by the checker file.
`ifndef FITCH_PARSIMONY_SITE_COMBINER_ASSERT_SVH
`define FITCH_PARSIMONY_SITE_COMBINER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPSC_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPSC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fpsc_pkg.sv
package fpsc_pkg;

    localparam int unsigned MAX_SITES_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam int unsigned SET_W      = 8;
    localparam int unsigned WEIGHT_W   = 32;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned ACC_W      = 48;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [SET_W-1:0] GAP_CODE_RESET     = 8'd16;
    localparam logic [SET_W-1:0] UNKNOWN_CODE_RESET = 8'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_WEIGHTS    = 8'd0,
        CFG_COUNT_MUTATIONS = 8'd1,
        CFG_GAP_CODE        = 8'd2,
        CFG_UNKNOWN_CODE    = 8'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        LEN_NONE   = 2'd0,
        LEN_SINGLE = 2'd1,
        LEN_DOUBLE = 2'd2
    } len_factor_t;

    typedef struct packed {
        logic             unit_weights;
        logic             count_mutations;
        logic [SET_W-1:0] gap_code;
        logic [SET_W-1:0] unknown_code;
    } fpsc_cfg_t;

    typedef struct packed {
        logic [SET_W-1:0]    parent_set;
        logic                bump;
        logic [WEIGHT_W-1:0] site_cost;
        logic [WEIGHT_W:0]   length_inc;
        logic                last_site;
    } fpsc_op_t;

    function automatic len_factor_t length_factor(
        input logic [SET_W-1:0] code,
        input logic [SET_W-1:0] gap,
        input logic [SET_W-1:0] unknown
    );
        len_factor_t f;
        if (code == gap || code == unknown)
        begin
            f = LEN_NONE;
        end
        else if (code == 8'd1 || code == 8'd2 || code == 8'd4 || code == 8'd8)
        begin
            f = LEN_DOUBLE;
        end
        else
        begin
            f = LEN_SINGLE;
        end
        return f;
    endfunction

endpackage

### hw/rtl/fpsc_ifs.sv
interface fpsc_in_if import fpsc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SET_W-1:0]    left_set;
    logic [SET_W-1:0]    right_set;
    logic [WEIGHT_W-1:0] site_weight;
    logic                last_site;

    modport source (output valid, output left_set, output right_set, output site_weight,
                    output last_site, input ready);
    modport sink   (input valid, input left_set, input right_set, input site_weight,
                    input last_site, output ready);
endinterface

interface fpsc_out_if import fpsc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SET_W-1:0]    parent_set;
    logic [WEIGHT_W-1:0] site_cost;
    logic [CNT_W-1:0]    mutation_count;
    logic [ACC_W-1:0]    total_cost;
    logic [ACC_W-1:0]    doubled_real_length;
    logic                end_of_sequence;

    modport source (output valid, output parent_set, output site_cost, output mutation_count,
                    output total_cost, output doubled_real_length, output end_of_sequence,
                    input ready);
    modport sink   (input valid, input parent_set, input site_cost, input mutation_count,
                    input total_cost, input doubled_real_length, input end_of_sequence,
                    output ready);
endinterface

interface fpsc_cfg_if import fpsc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/fpsc_ram.sv
module fpsc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/fpsc_front.sv
module fpsc_front import fpsc_pkg::*; #(
    parameter int unsigned MAX_SITES = MAX_SITES_DEF,
    localparam int unsigned AW       = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    fpsc_in_if.sink        site_in,
    input  fpsc_cfg_t      cfg,
    input  logic           clear_done,
    input  logic           q_full,
    output logic           push,
    output fpsc_op_t       op,
    output logic [AW-1:0]  pos
);

    localparam logic [AW-1:0] LAST_POS = AW'(MAX_SITES - 1);

    logic [AW-1:0]    pos_reg;
    logic [AW-1:0]    pos_next;
    logic [SET_W-1:0] both;
    logic             mismatch;
    len_factor_t      factor;

    assign site_in.ready = clear_done && !q_full;
    assign push          = site_in.valid && site_in.ready;

    always_comb
    begin
        both     = site_in.left_set & site_in.right_set;
        mismatch = (both == '0);

        op.parent_set = mismatch ? (site_in.left_set | site_in.right_set) : both;
        op.bump       = mismatch && cfg.count_mutations;
        op.last_site  = site_in.last_site;

        if (!mismatch)
        begin
            op.site_cost = '0;
        end
        else if (cfg.unit_weights && !cfg.count_mutations)
        begin
            op.site_cost = WEIGHT_W'(1);
        end
        else
        begin
            op.site_cost = site_in.site_weight;
        end

        factor = length_factor(op.parent_set, cfg.gap_code, cfg.unknown_code);
        case (factor)
            LEN_DOUBLE: op.length_inc = {site_in.site_weight, 1'b0};
            LEN_SINGLE: op.length_inc = {1'b0, site_in.site_weight};
            default:    op.length_inc = '0;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (site_in.last_site || pos_reg == LAST_POS)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

### hw/rtl/fpsc_queue.sv
module fpsc_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [PW:0]   FULL_CNT  = (PW + 1)'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW:0]      count_reg;
    logic [PW:0]      count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (PW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/fpsc_back.sv
module fpsc_back import fpsc_pkg::*; #(
    parameter int unsigned MAX_SITES = MAX_SITES_DEF,
    localparam int unsigned AW       = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  fpsc_op_t       q_op,
    input  logic [AW-1:0]  q_pos,
    output logic           q_pop,
    output logic           clear_done,
    fpsc_out_if.source     result_out
);

    localparam logic [AW-1:0] LAST_POS = AW'(MAX_SITES - 1);

    logic             clear_done_reg;
    logic [AW-1:0]    clr_addr_reg;

    logic             s1_valid_reg;
    fpsc_op_t         s1_op_reg;
    logic [AW-1:0]    s1_pos_reg;
    logic             fwd_hit_reg;
    logic [CNT_W-1:0] fwd_data_reg;

    logic [ACC_W-1:0] cost_acc_reg;
    logic [ACC_W-1:0] len_acc_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SET_W-1:0]    out_parent_reg;
    logic [WEIGHT_W-1:0] out_cost_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [ACC_W-1:0]    out_total_reg;
    logic [ACC_W-1:0]    out_length_reg;
    logic                out_end_reg;

    logic             out_free;
    logic             s1_fire;
    logic [CNT_W-1:0] ram_rdata;
    logic [CNT_W-1:0] cur_count;
    logic [CNT_W-1:0] new_count;
    logic [ACC_W-1:0] cost_sum;
    logic [ACC_W-1:0] len_sum;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CNT_W-1:0] ram_wdata;

    assign clear_done = clear_done_reg;
    assign out_free   = !out_valid_reg || result_out.ready;
    assign s1_fire    = s1_valid_reg && out_free;
    assign q_pop      = q_valid && clear_done_reg && (!s1_valid_reg || s1_fire);

    assign cur_count = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign new_count = cur_count + CNT_W'(s1_op_reg.bump);
    assign cost_sum  = cost_acc_reg + ACC_W'(s1_op_reg.site_cost);
    assign len_sum   = len_acc_reg + ACC_W'(s1_op_reg.length_inc);

    always_comb
    begin
        if (!clear_done_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_fire;
            ram_waddr = s1_pos_reg;
            ram_wdata = new_count;
        end
    end

    fpsc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_SITES)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_pos),
        .rdata (ram_rdata)
    );

    // sweep the counter store once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_done_reg <= 1'b0;
            clr_addr_reg   <= '0;
        end
        else if (!clear_done_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_POS)
            begin
                clear_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
                // forward the count written in the same cycle as this read
                fwd_hit_reg  <= s1_fire && (s1_pos_reg == q_pos);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_op_reg    <= q_op;
            s1_pos_reg   <= q_pos;
            fwd_data_reg <= new_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_acc_reg <= '0;
            len_acc_reg  <= '0;
        end
        else if (s1_fire)
        begin
            cost_acc_reg <= s1_op_reg.last_site ? '0 : cost_sum;
            len_acc_reg  <= s1_op_reg.last_site ? '0 : len_sum;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_parent_reg <= s1_op_reg.parent_set;
            out_cost_reg   <= s1_op_reg.site_cost;
            out_count_reg  <= new_count;
            out_total_reg  <= cost_sum;
            out_length_reg <= len_sum;
            out_end_reg    <= s1_op_reg.last_site;
        end
    end

    assign result_out.valid               = out_valid_reg;
    assign result_out.parent_set          = out_parent_reg;
    assign result_out.site_cost           = out_cost_reg;
    assign result_out.mutation_count      = out_count_reg;
    assign result_out.total_cost          = out_total_reg;
    assign result_out.doubled_real_length = out_length_reg;
    assign result_out.end_of_sequence     = out_end_reg;

endmodule

### hw/rtl/fitch_parsimony_site_combiner.sv
// An accepted site passes through the queue, the stage-1 register and the output
// register. Throughput: one site per cycle while result_out.ready is high; the
// per-site counter read-modify-write on the counter RAM forwards the previous write,
// so it never holds up the stream. Reset: asynchronous, active low; clears control
// and accumulators, then sweeps every counter RAM address, site_in.ready held low.
module fitch_parsimony_site_combiner import fpsc_pkg::*; #(
    parameter int unsigned MAX_SITES = MAX_SITES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fpsc_in_if.sink     site_in,
    fpsc_out_if.source  result_out,
    fpsc_cfg_if.sink    cfg
);

    localparam int unsigned AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int unsigned QW = $bits(fpsc_op_t) + AW;

    fpsc_cfg_t      cfg_reg;
    fpsc_cfg_t      cfg_next;
    logic           clear_done;
    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    logic           push;
    fpsc_op_t       front_op;
    logic [AW-1:0]  front_pos;
    logic [QW-1:0]  q_rd_data;
    fpsc_op_t       q_op;
    logic [AW-1:0]  q_pos;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_UNIT_WEIGHTS:    cfg_next.unit_weights    = cfg.data[0];
                CFG_COUNT_MUTATIONS: cfg_next.count_mutations = cfg.data[0];
                CFG_GAP_CODE:        cfg_next.gap_code        = cfg.data;
                CFG_UNKNOWN_CODE:    cfg_next.unknown_code    = cfg.data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_weights    <= 1'b0;
            cfg_reg.count_mutations <= 1'b0;
            cfg_reg.gap_code        <= GAP_CODE_RESET;
            cfg_reg.unknown_code    <= UNKNOWN_CODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fpsc_front #(
        .MAX_SITES (MAX_SITES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .site_in    (site_in),
        .cfg        (cfg_reg),
        .clear_done (clear_done),
        .q_full     (q_full),
        .push       (push),
        .op         (front_op),
        .pos        (front_pos)
    );

    fpsc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   ({front_op, front_pos}),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    assign q_op  = fpsc_op_t'(q_rd_data[QW-1:AW]);
    assign q_pos = q_rd_data[AW-1:0];

    fpsc_back #(
        .MAX_SITES (MAX_SITES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_op       (q_op),
        .q_pos      (q_pos),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .result_out (result_out)
    );

endmodule

### hw/rtl/fpsc_checker.sv
`include "fitch_parsimony_site_combiner_assert.svh"

module fpsc_checker import fpsc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SET_W-1:0]    parent_set,
    input logic [WEIGHT_W-1:0] site_cost,
    input logic [CNT_W-1:0]    mutation_count,
    input logic [ACC_W-1:0]    total_cost,
    input logic [ACC_W-1:0]    doubled_real_length,
    input logic                end_of_sequence
);

    logic prev_end_reg;
    logic [SET_W+WEIGHT_W+CNT_W+2*ACC_W:0] payload;

    assign payload = {parent_set, site_cost, mutation_count, total_cost, doubled_real_length,
                      end_of_sequence};

    // track whether the next result opens a fresh sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_end_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            prev_end_reg <= end_of_sequence;
        end
    end

    `FPSC_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_valid && !out_ready, out_valid,
        "result dropped while stalled")

    `FPSC_ASSERT_NEXT(a_out_payload_held, clk, rst_n, out_valid && !out_ready, $stable(payload),
        "result payload changed while stalled")

    `FPSC_ASSERT_SAME(a_fresh_total, clk, rst_n, out_valid && prev_end_reg,
        total_cost == ACC_W'(site_cost), "cost total not restarted after sequence end")

    `FPSC_ASSERT_SAME(a_clear_blocks_input, clk, rst_n, $rose(rst_n), !in_ready,
        "site accepted before counter store cleared")

endmodule

bind fitch_parsimony_site_combiner fpsc_checker u_fpsc_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ready            (site_in.ready),
    .out_valid           (result_out.valid),
    .out_ready           (result_out.ready),
    .parent_set          (result_out.parent_set),
    .site_cost           (result_out.site_cost),
    .mutation_count      (result_out.mutation_count),
    .total_cost          (result_out.total_cost),
    .doubled_real_length (result_out.doubled_real_length),
    .end_of_sequence     (result_out.end_of_sequence)
);
